[rtl/core/tpb_pkg.sv]
// Shared constants and types for the timed peer blocklist.
`default_nettype none
package tpb_pkg;

  localparam int unsigned TABLE_DEPTH_DEFAULT = 16;

  localparam int unsigned PEER_W    = 32;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned SPAN_W    = 40;
  localparam int unsigned ENTRIES_W = 5;
  localparam int unsigned ENTRY_W   = PEER_W + TIME_W;

  localparam logic [SPAN_W-1:0] EXPIRY_RESET = SPAN_W'(600000000);

  // Request kinds.
  localparam logic REQ_QUERY = 1'b0;
  localparam logic REQ_ADD   = 1'b1;

  typedef enum logic [1:0] {
    OUT_NONE    = 2'd0,
    OUT_REFRESH = 2'd1,
    OUT_INSERT  = 2'd2,
    OUT_DROP    = 2'd3
  } outcome_t;

endpackage
`default_nettype wire

[rtl/core/tpb_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module tpb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[rtl/core/timed_peer_blocklist_core.sv]
// Top level of the timed peer blocklist: sequencer, shared age compare and table RAM.
// A query scans the used entries for a live match. An add refreshes a matching entry,
// or else runs an eviction pass that removes expired entries and then inserts the peer,
// dropped when the table is full. With an empty table the scan is skipped; peer zero
// skips the table.
// One transaction at a time, set by the single RAM read port and the shared age compare.
// Reset clears count, sequencer and output valid and loads the default span; rows stay.
`default_nettype none
module timed_peer_blocklist_core
  import tpb_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,

  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 req_type,
  input  wire logic [PEER_W-1:0]    peer_key,
  input  wire logic [TIME_W-1:0]    now_time,

  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      is_blocked,
  output logic [1:0]                add_outcome,
  output logic [ENTRIES_W-1:0]      entries_used,

  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [SPAN_W-1:0]    cfg_data
);

  localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  // One-hot sequencer states.
  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SCAN    = 7'b0000010,
    S_EV_RD   = 7'b0000100,
    S_EV_CHK  = 7'b0001000,
    S_EV_MOVE = 7'b0010000,
    S_INSERT  = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t             state;
  logic               req_kind;
  logic [PEER_W-1:0]  req_key;
  logic [TIME_W-1:0]  req_now;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   used_count;
  logic [SPAN_W-1:0]  expiry_span;
  logic               res_blocked;
  outcome_t           res_outcome;
  outcome_t           out_outcome;

  logic               ram_wr_en;
  logic [ADDR_W-1:0]  ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic [ADDR_W-1:0]  ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;

  logic [PEER_W-1:0]  rd_peer;
  logic [TIME_W-1:0]  rd_stamp;
  logic [TIME_W:0]    age_diff;
  logic               entry_expired;
  logic               peer_match;
  logic [CNT_W-1:0]   idx_inc;
  logic [CNT_W-1:0]   used_dec;
  logic               in_take;
  logic               out_free;

  // Each table row packs the peer id above its stamp.
  assign rd_peer  = ram_rd_data[ENTRY_W-1:TIME_W];
  assign rd_stamp = ram_rd_data[TIME_W-1:0];

  // The shared age unit: one subtract and one compare, used by both the lookup scan
  // and the eviction pass. A stamp after the current time gives a borrow, and such
  // an entry is never treated as expired.
  assign age_diff      = {1'b0, req_now} - {1'b0, rd_stamp};
  assign entry_expired = !age_diff[TIME_W] &&
                         (age_diff[TIME_W-1:0] >= TIME_W'(expiry_span));
  assign peer_match    = (rd_peer == req_key);

  assign idx_inc  = idx + CNT_W'(1);
  assign used_dec = used_count - CNT_W'(1);

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // The output register can be loaded when it is empty or its transaction leaves now.
  assign out_free  = !out_valid || !out_stall;

  // RAM read address selection. The read issued in one state returns data in the next.
  always_comb begin
    unique case (state)
      S_IDLE:   ram_rd_addr = '0;
      S_SCAN:   ram_rd_addr = idx_inc[ADDR_W-1:0];
      S_EV_RD:  ram_rd_addr = idx[ADDR_W-1:0];
      S_EV_CHK: ram_rd_addr = used_dec[ADDR_W-1:0];
      default:  ram_rd_addr = '0;
    endcase
  end

  // RAM write selection: refresh of a matching entry, the move of the last entry
  // into an evicted slot, or the append of a new peer.
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = idx[ADDR_W-1:0];
    ram_wr_data = {req_key, req_now};
    unique case (state)
      S_SCAN: begin
        ram_wr_en = (req_kind == REQ_ADD) && peer_match;
      end
      S_EV_MOVE: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = ram_rd_data;
      end
      S_INSERT: begin
        ram_wr_en   = (used_count < DEPTH_CNT);
        ram_wr_addr = used_count[ADDR_W-1:0];
      end
      default: begin
        ram_wr_en = 1'b0;
      end
    endcase
  end

  tpb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Configuration register. Write only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      expiry_span <= EXPIRY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      expiry_span <= cfg_data;
    end
  end

  // Request capture and sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            req_kind    <= req_type;
            req_key     <= peer_key;
            req_now     <= now_time;
            idx         <= '0;
            res_blocked <= 1'b0;
            res_outcome <= OUT_NONE;
            if (peer_key == '0) begin
              // Peer zero is never blocked and is never added.
              state <= S_DONE;
            end else if (used_count == '0) begin
              state <= (req_type == REQ_ADD) ? S_INSERT : S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // The entry at idx is on the read port; the next one is being fetched.
          if (req_kind == REQ_QUERY) begin
            if (peer_match && !entry_expired) begin
              res_blocked <= 1'b1;
              state       <= S_DONE;
            end else if (idx_inc == used_count) begin
              state <= S_DONE;
            end else begin
              idx <= idx_inc;
            end
          end else begin
            if (peer_match) begin
              // The stamp is rewritten even when the entry has already expired.
              res_outcome <= OUT_REFRESH;
              state       <= S_DONE;
            end else if (idx_inc == used_count) begin
              idx   <= '0;
              state <= S_EV_RD;
            end else begin
              idx <= idx_inc;
            end
          end
        end
        S_EV_RD: begin
          state <= (idx == used_count) ? S_INSERT : S_EV_CHK;
        end
        S_EV_CHK: begin
          if (entry_expired) begin
            // Shrink the table and pull the last entry into this slot.
            used_count <= used_dec;
            state      <= S_EV_MOVE;
          end else begin
            idx   <= idx_inc;
            state <= S_EV_RD;
          end
        end
        S_EV_MOVE: begin
          // The moved entry is checked again from the same slot.
          state <= S_EV_RD;
        end
        S_INSERT: begin
          if (used_count < DEPTH_CNT) begin
            used_count  <= used_count + CNT_W'(1);
            res_outcome <= OUT_INSERT;
          end else begin
            res_outcome <= OUT_DROP;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register. A finished result waits here until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid    <= 1'b1;
      is_blocked   <= res_blocked;
      out_outcome  <= res_outcome;
      entries_used <= ENTRIES_W'(used_count);
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign add_outcome = out_outcome;

endmodule
`default_nettype wire
